FILE: sv/pal_pkg.sv
`default_nettype none
// Shared types and constants for the positional array list.
// No dependencies; every other file of the block imports this package.
package pal_pkg;

   // Defaults and the largest supported configuration.
   localparam int unsigned CAPACITY_DEF   = 64;
   localparam int unsigned WORD_WIDTH_DEF = 32;
   localparam int unsigned CAPACITY_MAX   = 4096;
   localparam int unsigned WORD_W_MAX     = 64;
   localparam int unsigned LEN_W_MAX      = $clog2(CAPACITY_MAX + 1);

   // Longest run a single delete or read may ask for.
   localparam int unsigned MAX_RUN = 64;

   // Depth of the job queue between front and back (a power of two).
   localparam int unsigned QDEPTH = 2;

   // Operation codes.
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_FIND   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;
   localparam logic [2:0] OP_LENGTH = 3'd5;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_POS   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // What the back end has to do for one item.
   typedef enum logic [1:0] {
      JOB_REPLY  = 2'd0,
      JOB_INSERT = 2'd1,
      JOB_RUN    = 2'd2,
      JOB_FIND   = 2'd3
   } job_kind_type;

   // One classified item, sized for the largest configuration.
   typedef struct packed {
      job_kind_type           kind;
      logic                   remove;
      logic [2:0]             status;
      logic [LEN_W_MAX-1:0]   len_before;
      logic [LEN_W_MAX-1:0]   len_after;
      logic [LEN_W_MAX-1:0]   start;
      logic [6:0]             count;
      logic [WORD_W_MAX-1:0]  value;
   } job_type;

endpackage
`default_nettype wire

FILE: sv/pal_front.sv
`default_nettype none
// Front end: checks each item against the list length and turns it into a job.
// Depends on pal_pkg.
module pal_front #(
   parameter int unsigned CAPACITY = pal_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [2:0]       req_op,
   input  wire logic [6:0]       req_position,
   input  wire logic [6:0]       req_count,
   input  wire logic [31:0]      req_value,
   output pal_pkg::job_type      job,
   output logic                  push
);
   import pal_pkg::*;

   localparam int unsigned LW = $clog2(CAPACITY + 1);
   localparam int unsigned EW = ((LW > 7) ? LW : 7) + 2;

   logic [LW-1:0] len_ff, len_in;
   logic [EW-1:0] pos_e, cnt_e, len_e;
   logic          run_bad, run_range;

   assign pos_e = EW'(req_position);
   assign cnt_e = EW'(req_count);
   assign len_e = EW'(len_ff);

   assign run_bad   = (req_position == 7'd0) || (req_count == 7'd0) ||
                      (cnt_e > EW'(MAX_RUN));
   assign run_range = (pos_e + cnt_e - EW'(1)) > len_e;
   assign push      = accept;

   always_comb begin
      job            = '0;
      job.kind       = JOB_REPLY;
      job.status     = ST_OK;
      job.len_before = LEN_W_MAX'(len_ff);
      job.len_after  = LEN_W_MAX'(len_ff);
      job.start      = LEN_W_MAX'(req_position - 7'd1);
      job.count      = req_count;
      job.value      = WORD_W_MAX'(req_value);
      len_in         = len_ff;
      case (req_op)
         OP_INSERT: begin
            if ((req_position == 7'd0) || (pos_e > len_e + EW'(1))) begin
               job.status = ST_BAD_POS;
            end else if (len_e >= EW'(CAPACITY)) begin
               job.status = ST_FULL;
            end else begin
               job.kind      = JOB_INSERT;
               len_in        = len_ff + LW'(1);
               job.len_after = LEN_W_MAX'(len_in);
            end
         end
         OP_DELETE, OP_READ: begin
            if (run_bad) begin
               job.status = ST_BAD_POS;
            end else if (run_range) begin
               job.status = ST_RANGE;
            end else begin
               job.kind   = JOB_RUN;
               job.remove = (req_op == OP_DELETE);
               if (req_op == OP_DELETE) begin
                  len_in = len_ff - LW'(req_count);
               end
               job.len_after = LEN_W_MAX'(len_in);
            end
         end
         OP_FIND: begin
            job.kind = JOB_FIND;
         end
         OP_CLEAR: begin
            len_in        = '0;
            job.len_after = '0;
         end
         default: begin
            job.kind = JOB_REPLY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (accept) begin
         len_ff <= len_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/pal_queue.sv
`default_nettype none
// Short job queue that decouples the front end from the back end.
// Depends on pal_pkg.
module pal_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pal_pkg::job_type  push_job,
   input  wire logic              pop,
   output pal_pkg::job_type       head,
   output logic                   valid,
   output logic                   full
);
   import pal_pkg::*;

   localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned CW = $clog2(QDEPTH + 1);

   job_type       slot_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] fill_ff;

   assign head  = slot_ff[rd_ptr_ff];
   assign valid = (fill_ff != '0);
   assign full  = (fill_ff == CW'(QDEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/pal_back.sv
`default_nettype none
// Back end: owns the entry memory and sweeps it to insert, delete, read and find.
// Depends on pal_pkg.
module pal_back #(
   parameter int unsigned CAPACITY   = pal_pkg::CAPACITY_DEF,
   parameter int unsigned WORD_WIDTH = pal_pkg::WORD_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pal_pkg::job_type q_head,
   input  wire logic             q_valid,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output logic [31:0]           rsp_word_out,
   output logic [5:0]            rsp_found_index,
   output logic [6:0]            rsp_list_len,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);
   import pal_pkg::*;

   localparam int unsigned LW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_INS_RD   = 10'b00_0000_0010,
      S_INS_MV   = 10'b00_0000_0100,
      S_INS_PUT  = 10'b00_0000_1000,
      S_RUN_RD   = 10'b00_0001_0000,
      S_RUN_OUT  = 10'b00_0010_0000,
      S_CMP_RD   = 10'b00_0100_0000,
      S_CMP_MV   = 10'b00_1000_0000,
      S_FIND_RD  = 10'b01_0000_0000,
      S_FIND_CMP = 10'b10_0000_0000
   } state_type;

   state_type             state_ff, state_in;
   job_type               cur_ff, cur_in;
   logic [LW-1:0]         i_ff, i_in;
   logic [6:0]            k_ff, k_in;

   logic [WORD_WIDTH-1:0] mem [CAPACITY];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;

   logic                  emit;
   logic [31:0]           e_word;
   logic [5:0]            e_idx;
   logic [2:0]            e_status;
   logic [LEN_W_MAX-1:0]  e_len;
   logic                  e_last;

   logic                  strobe_ff;
   logic [31:0]           word_ff;
   logic [5:0]            idx_ff;
   logic [6:0]            len_ff;
   logic [2:0]            status_ff;
   logic                  last_ff;

   logic [LW-1:0]         start_i, lenb_i, cnt_i, head_start, head_lenb;
   logic [WORD_W_MAX-1:0] word_wide;
   logic                  run_done;

   assign start_i    = LW'(cur_ff.start);
   assign lenb_i     = LW'(cur_ff.len_before);
   assign cnt_i      = LW'(cur_ff.count);
   assign head_start = LW'(q_head.start);
   assign head_lenb  = LW'(q_head.len_before);
   assign word_wide  = WORD_W_MAX'(rd_data_ff);
   assign run_done   = ((k_ff + 7'd1) == cur_ff.count);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      emit     = 1'b0;
      e_word   = '0;
      e_idx    = '0;
      e_status = ST_OK;
      e_len    = cur_ff.len_after;
      e_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               e_len  = q_head.len_after;
               case (q_head.kind)
                  JOB_INSERT: begin
                     i_in = head_lenb;
                     if (head_lenb > head_start) begin
                        state_in = S_INS_RD;
                     end else begin
                        state_in = S_INS_PUT;
                     end
                  end
                  JOB_RUN: begin
                     k_in     = '0;
                     state_in = S_RUN_RD;
                  end
                  JOB_FIND: begin
                     i_in = '0;
                     if (head_lenb == '0) begin
                        emit     = 1'b1;
                        e_status = ST_NOT_FOUND;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  default: begin
                     emit     = 1'b1;
                     e_status = q_head.status;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(i_ff - LW'(1));
            state_in = S_INS_MV;
         end
         S_INS_MV: begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_ff);
            wr_data = rd_data_ff;
            i_in    = i_ff - LW'(1);
            if ((i_ff - LW'(1)) > start_i) begin
               state_in = S_INS_RD;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(start_i);
            wr_data  = cur_ff.value[WORD_WIDTH-1:0];
            emit     = 1'b1;
            state_in = S_IDLE;
         end
         S_RUN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(start_i + LW'(k_ff));
            state_in = S_RUN_OUT;
         end
         S_RUN_OUT: begin
            emit   = 1'b1;
            e_word = word_wide[31:0];
            e_last = run_done;
            if (!run_done) begin
               k_in     = k_ff + 7'd1;
               state_in = S_RUN_RD;
            end else if (cur_ff.remove &&
                         ((LW + 1)'(start_i) + (LW + 1)'(cnt_i) < (LW + 1)'(lenb_i))) begin
               i_in     = start_i;
               state_in = S_CMP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(i_ff + cnt_i);
            state_in = S_CMP_MV;
         end
         S_CMP_MV: begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_ff);
            wr_data = rd_data_ff;
            i_in    = i_ff + LW'(1);
            if ((LW + 1)'(i_ff) + (LW + 1)'(1) + (LW + 1)'(cnt_i) < (LW + 1)'(lenb_i)) begin
               state_in = S_CMP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIND_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(i_ff);
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (rd_data_ff == cur_ff.value[WORD_WIDTH-1:0]) begin
               emit     = 1'b1;
               e_idx    = 6'(i_ff);
               state_in = S_IDLE;
            end else if ((LW + 1)'(i_ff) + (LW + 1)'(1) < (LW + 1)'(lenb_i)) begin
               i_in     = i_ff + LW'(1);
               state_in = S_FIND_RD;
            end else begin
               emit     = 1'b1;
               e_status = ST_NOT_FOUND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      i_ff   <= i_in;
      k_ff   <= k_in;
      if (emit) begin
         word_ff   <= e_word;
         idx_ff    <= e_idx;
         len_ff    <= 7'(e_len);
         status_ff <= e_status;
         last_ff   <= e_last;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_word_out    = word_ff;
   assign rsp_found_index = idx_ff;
   assign rsp_list_len    = len_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

FILE: sv/positional_array_list.sv
`default_nettype none
// Positional array list: an ordered list of up to CAPACITY words, 1-based positions.
// Holds the top level; instantiates pal_front, pal_queue and pal_back and imports pal_pkg.
//
// Using the block: raise start with an item on the req_ ports; the item is taken at
// any clock edge where start is high and busy is low. Every item answers with one or
// more results, each shown for exactly one cycle with rsp_strobe high and rsp_last
// high on the final one; the receiver cannot stall, so capture every strobe. The
// front end checks an item against the running length in the cycle it is taken and
// files it in a two-deep job queue; busy is high only while that queue is full. The
// back end takes a job from the queue, then works on an entry memory with one write
// port and one registered read port, so each word moved or returned is read first:
//   length query, clear, and any rejected item: no memory work, results back to back;
//   insert at position p into a list of n words: the n-p+1 words from p move up
//   one place, then the new word is written;
//   read of c words: c results, one per word read;
//   delete of c words at p: c results, then the n-p+1-c words behind the run move
//   down to close the gap before the next job starts;
//   find: a scan from the first word up to the first match or the end; an empty list is not read.
// The entry memory needs no clearing after reset: only words below the length are
// ever read.
module positional_array_list #(
   parameter int unsigned CAPACITY   = pal_pkg::CAPACITY_DEF,
   parameter int unsigned WORD_WIDTH = pal_pkg::WORD_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [6:0]  req_position,
   input  wire logic [6:0]  req_count,
   input  wire logic [31:0] req_value,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_word_out,
   output logic [5:0]       rsp_found_index,
   output logic [6:0]       rsp_list_len,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);
   import pal_pkg::*;

   job_type new_job, head_job;
   logic    accept, push, pop, q_valid, q_full;

   // Take an item whenever the queue has room.
   assign busy   = q_full;
   assign accept = start && !busy;

   // Classify the item and advance the running length.
   pal_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_op       (req_op),
      .req_position (req_position),
      .req_count    (req_count),
      .req_value    (req_value),
      .job          (new_job),
      .push         (push)
   );

   // Hold classified jobs until the back end is free.
   pal_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .pop      (pop),
      .head     (head_job),
      .valid    (q_valid),
      .full     (q_full)
   );

   // Carry out each job on the entry memory and drive the results.
   pal_back #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (head_job),
      .q_valid         (q_valid),
      .q_pop           (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_word_out    (rsp_word_out),
      .rsp_found_index (rsp_found_index),
      .rsp_list_len    (rsp_list_len),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
